// ===== src/utv_pkg.sv =====
// Shared types and constants for the UTF-8 text validator.
`default_nettype none

package utv_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = LenW + 1;
  localparam int unsigned CpW    = 21;

  localparam logic [LenW-1:0] MaxLengthReset = 16'd16384;

  localparam logic [7:0] Lead2Lo   = 8'hc2;
  localparam logic [7:0] Lead2Hi   = 8'hdf;
  localparam logic [7:0] Lead3Lo   = 8'he0;
  localparam logic [7:0] Lead3Hi   = 8'hef;
  localparam logic [7:0] Lead4Lo   = 8'hf0;
  localparam logic [7:0] Lead4Hi   = 8'hf4;
  localparam logic [7:0] CtrlLimit = 8'd32;
  localparam logic [7:0] DelByte   = 8'd127;
  localparam logic [7:0] SpaceByte = 8'h20;

  localparam logic [CpW-1:0] Min2Byte  = 21'h80;
  localparam logic [CpW-1:0] Min3Byte  = 21'h800;
  localparam logic [CpW-1:0] Min4Byte  = 21'h10000;
  localparam logic [CpW-1:0] MaxPoint  = 21'h10ffff;
  localparam logic [CpW-1:0] SurrLo    = 21'hd800;
  localparam logic [CpW-1:0] SurrHi    = 21'hdfff;

  // Register indexes on the configuration port.
  localparam logic CfgMaxLength       = 1'b0;
  localparam logic CfgRequireNonblank = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_BLANK     = 3'd2,
    ERR_CONTROL   = 3'd3,
    ERR_BAD_LEAD  = 3'd4,
    ERR_BAD_CONT  = 3'd5,
    ERR_TRUNCATED = 3'd6,
    ERR_BAD_POINT = 3'd7
  } err_kind_t;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] max_length;
    logic            require_nonblank;
  } cfg_t;

  typedef struct packed {
    logic      text_ok;
    err_kind_t error_kind;
  } result_t;

endpackage

`default_nettype wire

// ===== src/utv_in_stage.sv =====
// Input register stage: holds one accepted request until the checker takes it.
`default_nettype none

module utv_in_stage
  import utv_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  wire   take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== src/utv_check.sv =====
// String state and the per-byte UTF-8, length and blank checks.
`default_nettype none

module utv_check
  import utv_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  cfg_t    cfg,
  input  wire     step,
  input  item_t   item,
  output result_t result
);

  logic [CountW-1:0] count_r, count_nxt;
  logic [1:0]        pending_r, pending_nxt;
  logic [CpW-1:0]    acc_r, acc_nxt;
  seq_class_t        class_r, class_nxt;
  err_kind_t         ferr_r, ferr_nxt;
  logic              spaces_r, spaces_nxt;

  logic [7:0]        c;
  logic [CpW-1:0]    acc_shift;
  logic [CpW-1:0]    minimum;
  err_kind_t         ferr_end;

  assign c         = item.data_byte;
  assign acc_shift = {acc_r[CpW-7:0], c[5:0]};

  always_comb begin
    case (class_r)
      SEQ_TWO:   minimum = Min2Byte;
      SEQ_THREE: minimum = Min3Byte;
      default:   minimum = Min4Byte;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    pending_nxt = pending_r;
    acc_nxt     = acc_r;
    class_nxt   = class_r;
    ferr_nxt    = ferr_r;
    spaces_nxt  = spaces_r;
    ferr_end    = ERR_NONE;
    result      = '{text_ok: 1'b1, error_kind: ERR_NONE};

    if (item.has_byte) begin
      if (count_r <= {1'b0, cfg.max_length}) begin
        count_nxt = count_r + 1'b1;
      end
      if (c != SpaceByte) begin
        spaces_nxt = 1'b0;
      end
      if (ferr_r == ERR_NONE) begin
        if (pending_r == 2'd0) begin
          if (c < CtrlLimit || c == DelByte) begin
            ferr_nxt = ERR_CONTROL;
          end else if (!c[7]) begin
            ferr_nxt = ERR_NONE;
          end else if (c >= Lead2Lo && c <= Lead2Hi) begin
            acc_nxt     = {16'd0, c[4:0]};
            class_nxt   = SEQ_TWO;
            pending_nxt = 2'd1;
          end else if (c >= Lead3Lo && c <= Lead3Hi) begin
            acc_nxt     = {17'd0, c[3:0]};
            class_nxt   = SEQ_THREE;
            pending_nxt = 2'd2;
          end else if (c >= Lead4Lo && c <= Lead4Hi) begin
            acc_nxt     = {18'd0, c[2:0]};
            class_nxt   = SEQ_FOUR;
            pending_nxt = 2'd3;
          end else begin
            ferr_nxt = ERR_BAD_LEAD;
          end
        end else if (c[7:6] != 2'b10) begin
          ferr_nxt = ERR_BAD_CONT;
        end else begin
          acc_nxt     = acc_shift;
          pending_nxt = pending_r - 2'd1;
          // The last continuation byte closes the sequence: check its range.
          if (pending_r == 2'd1 &&
              (acc_shift < minimum || acc_shift > MaxPoint ||
               (acc_shift >= SurrLo && acc_shift <= SurrHi))) begin
            ferr_nxt = ERR_BAD_POINT;
          end
        end
      end
    end

    if (item.end_of_text) begin
      ferr_end = ferr_nxt;
      if (ferr_nxt == ERR_NONE && pending_nxt != 2'd0) begin
        ferr_end = ERR_TRUNCATED;
      end
      if (count_nxt > {1'b0, cfg.max_length}) begin
        result.error_kind = ERR_TOO_LONG;
      end else if (cfg.require_nonblank && spaces_nxt) begin
        result.error_kind = ERR_BLANK;
      end else begin
        result.error_kind = ferr_end;
      end
      result.text_ok = (result.error_kind == ERR_NONE);

      count_nxt   = '0;
      pending_nxt = 2'd0;
      acc_nxt     = '0;
      class_nxt   = SEQ_NONE;
      ferr_nxt    = ERR_NONE;
      spaces_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pending_r <= 2'd0;
      acc_r     <= '0;
      class_r   <= SEQ_NONE;
      ferr_r    <= ERR_NONE;
      spaces_r  <= 1'b1;
    end else if (step) begin
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      acc_r     <= acc_nxt;
      class_r   <= class_nxt;
      ferr_r    <= ferr_nxt;
      spaces_r  <= spaces_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8_text_validator.sv =====
// Top level of the UTF-8 text validator: config registers, stages and result register.
// A request carrying the end mark passes the input stage and then the result register.
// Throughput: one byte per cycle; the string state registers update once per byte.
// A waiting result does not block the next byte unless that byte also ends a string.
// Reset (synchronous, rst_n low) empties both stages, clears the string state and
// sets max_length to 16384 and require_nonblank to 1.
`default_nettype none

module utf8_text_validator
  import utv_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] has_byte
  input  wire         in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [0] text_ok, [3:1] error_kind, [7:4] zero
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    out_free;
  result_t result;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_item = '{data_byte: in_tdata, has_byte: in_tuser, end_of_text: in_tlast};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_length: MaxLengthReset, require_nonblank: 1'b1};
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgMaxLength:       cfg_r.max_length       <= cfg_wdata;
        CfgRequireNonblank: cfg_r.require_nonblank <= cfg_wdata[0];
        default:            cfg_r                  <= cfg_r;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign take     = item_valid && (!item.end_of_text || out_free);

  utv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  utv_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .step   (take),
    .item   (item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && item.end_of_text) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.end_of_text) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.error_kind, res_r.text_ok};

endmodule

`default_nettype wire
